// File: rtl/glfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glfr_pkg;

	localparam int STORE_DEPTH  = 1024;
	localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
	localparam int WORD_W       = 8;

	localparam logic [1:0] OP_DRAW    = 2'd0;
	localparam logic [1:0] OP_REFRESH = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [5:0] STEP_ROW_CMD = 6'd32;
	localparam logic [5:0] STEP_COL_CMD = 6'd33;

	localparam logic [7:0] BASE_RESET = 8'h80;

	typedef struct packed {
		logic                    en;
		logic [STORE_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]       data;
	} glfr_wr_t;

endpackage : glfr_pkg

`default_nettype wire

// File: rtl/glfr_store.sv
`timescale 1ns / 1ps
`default_nettype none

module glfr_store
	import glfr_pkg::*;
(
	input  wire logic                    clk,
	input  wire glfr_wr_t                wr,
	input  wire logic                    rd_en,
	input  wire logic [STORE_ADDR_W-1:0] rd_addr,
	output logic      [WORD_W-1:0]       rd_data
);

	logic [WORD_W-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : glfr_store

`default_nettype wire

// File: rtl/graphic_lcd_framebuffer_refresh.sv
`timescale 1ns / 1ps
`default_nettype none

// 128x64 monochrome framebuffer with a display refresh sequencer. A command is taken
// when start is high and busy is low. A refresh tick puts its bus word on
// bus_byte/is_data with strobe high in the following cycle; another command may be
// taken in that same cycle. A pixel draw is a read and a write-back of one store word
// through the store's read and write ports. A clear, and the sweep that follows reset,
// writes zero to all 1024 words one per cycle, holding busy high throughout;
// configuration writes are still taken meanwhile. The receiver cannot stall: each word
// is shown for exactly one cycle.
module graphic_lcd_framebuffer_refresh
	import glfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] pixel_x,
	input  wire logic [15:0] pixel_y,
	input  wire logic        pixel_on,
	output logic             strobe,
	output logic [7:0]       bus_byte,
	output logic             is_data,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_DRAW  = 2'd2;

	logic [1:0]              state_q;
	logic [STORE_ADDR_W-1:0] clr_cnt_q;
	logic [STORE_ADDR_W-1:0] draw_addr_q;
	logic [WORD_W-1:0]       draw_mask_q;
	logic                    draw_on_q;
	logic [5:0]              step_q;
	logic [4:0]              row_q;
	logic [7:0]              base_q;
	logic                    strobe_q;
	logic                    is_data_q;
	logic                    from_mem_q;
	logic [7:0]              byte_q;

	logic                    accept;
	logic                    on_panel;
	logic [STORE_ADDR_W-1:0] pix_addr;
	logic [4:0]              row_next;
	logic                    rd_en;
	logic [STORE_ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0]       rd_data;
	glfr_wr_t                wr;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign on_panel = (pixel_x[15:7] == 9'd0) && (pixel_y[15:6] == 10'd0);
	// upper half in byte columns 0..15, lower half in 16..31
	assign pix_addr = {pixel_y[5], pixel_x[6:3], pixel_y[4:0]};
	assign row_next = row_q + 5'd1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pix_addr;
		if (accept && (operation == OP_DRAW) && on_panel) begin
			rd_en = 1'b1;
		end else if (accept && (operation == OP_REFRESH) && !step_q[5]) begin
			rd_en   = 1'b1;
			rd_addr = {step_q[4:0], row_q};
		end
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = clr_cnt_q;
		wr.data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr.en = 1'b1;
			end
			ST_DRAW: begin
				wr.en   = 1'b1;
				wr.addr = draw_addr_q;
				wr.data = draw_on_q ? (rd_data | draw_mask_q) : (rd_data & ~draw_mask_q);
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	glfr_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == STORE_ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && (operation == OP_DRAW) && on_panel) begin
						state_q <= ST_DRAW;
					end else if (accept && (operation == OP_CLEAR)) begin
						state_q   <= ST_CLEAR;
						clr_cnt_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && (operation == OP_DRAW)) begin
			draw_addr_q <= pix_addr;
			draw_mask_q <= 8'h80 >> pixel_x[2:0];
			draw_on_q   <= pixel_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_ROW_CMD;
			row_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= accept && (operation == OP_REFRESH);
			if (accept && (operation == OP_REFRESH)) begin
				priority if (step_q == STEP_COL_CMD) begin
					step_q <= '0;
				end else if (!step_q[5]) begin
					step_q <= step_q + 6'd1;
				end else begin
					row_q  <= row_next;
					step_q <= STEP_COL_CMD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_REFRESH)) begin
			priority if (step_q == STEP_COL_CMD) begin
				byte_q     <= base_q;
				is_data_q  <= 1'b0;
				from_mem_q <= 1'b0;
			end else if (!step_q[5]) begin
				is_data_q  <= 1'b1;
				from_mem_q <= 1'b1;
			end else begin
				byte_q     <= base_q | {3'b000, row_next};
				is_data_q  <= 1'b0;
				from_mem_q <= 1'b0;
			end
		end
	end

	assign strobe   = strobe_q;
	assign is_data  = is_data_q;
	assign bus_byte = from_mem_q ? rd_data : byte_q;

endmodule : graphic_lcd_framebuffer_refresh

`default_nettype wire
